@@ src/tdwq_pkg.sv @@
package tdwq_pkg;

	localparam int QUEUE_DEPTH  = 32;
	localparam int TASK_ID_BITS = 8;
	localparam int IDX_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1);
	localparam int SUM_W        = CNT_W + 1;
	localparam int ENTRY_W      = 32 + TASK_ID_BITS;

	typedef enum logic [1:0] {
		KIND_TICK  = 2'd0,
		KIND_TIME  = 2'd1,
		KIND_DELAY = 2'd2,
		KIND_UNTIL = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		REPLY_ACK    = 2'd0,
		REPLY_TIME   = 2'd1,
		REPLY_WAKE   = 2'd2,
		REPLY_REJECT = 2'd3
	} reply_t;

	typedef struct packed {
		kind_t              kind;
		logic [7:0]         task_id;
		logic signed [31:0] tick_value;
	} cmd_t;

	typedef struct packed {
		reply_t             reply_kind;
		logic [7:0]         dest_task;
		logic signed [31:0] time_value;
		logic               last;
	} result_t;

	// result handoff from the sequencer to the output stage
	typedef struct packed {
		logic               valid;
		logic               fin;
		reply_t             reply_kind;
		logic [7:0]         dest_task;
		logic signed [31:0] time_value;
	} emit_t;

	typedef struct packed {
		logic                         we;
		logic [IDX_W-1:0]             waddr;
		logic [ENTRY_W-1:0]           wdata;
		logic                         re;
		logic [IDX_W-1:0]             raddr;
	} mem_req_t;

	function automatic logic [TASK_ID_BITS-1:0] to_stored(input logic [7:0] t);
		logic [15:0]             w;
		logic [TASK_ID_BITS-1:0] r;
		w = {8'b0, t};
		for (int i = 0; i < TASK_ID_BITS; i++) begin
			r[i] = w[i];
		end
		return r;
	endfunction

	function automatic logic [7:0] from_stored(input logic [TASK_ID_BITS-1:0] s);
		logic [15:0] w;
		w = '0;
		for (int i = 0; i < TASK_ID_BITS; i++) begin
			w[i] = s[i];
		end
		return w[7:0];
	endfunction

	function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] a);
		return (a == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : IDX_W'(a + 1'b1);
	endfunction

	function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] a,
			input logic [CNT_W-1:0] b);
		logic [SUM_W-1:0] s;
		s = SUM_W'(a) + SUM_W'(b);
		if (s >= SUM_W'(QUEUE_DEPTH)) begin
			s = s - SUM_W'(QUEUE_DEPTH);
		end
		return IDX_W'(s);
	endfunction

endpackage

@@ src/tdwq_ram.sv @@
module tdwq_ram #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 40,
	parameter int AW    = 5
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ src/tdwq_ctrl.sv @@
module tdwq_ctrl (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  tdwq_pkg::cmd_t                         cmd,
	output logic                                   busy,
	output tdwq_pkg::mem_req_t                     mreq,
	input  logic [tdwq_pkg::ENTRY_W-1:0]           rdata,
	output tdwq_pkg::emit_t                        emit
);

	typedef enum logic [1:0] {IDLE, SCAN, FINISH} state_t;

	state_t                          state_q;
	logic signed [31:0]              ticks_q;
	logic [tdwq_pkg::IDX_W-1:0]      head_q;
	logic [tdwq_pkg::CNT_W-1:0]      count_q;
	logic [tdwq_pkg::IDX_W-1:0]      rd_q;
	logic [tdwq_pkg::IDX_W-1:0]      wr_q;
	logic [tdwq_pkg::IDX_W-1:0]      new_head_q;
	logic [tdwq_pkg::CNT_W-1:0]      rem_q;
	logic [tdwq_pkg::CNT_W-1:0]      kept_q;
	logic                            vld_s1;

	logic                            accept;
	logic [tdwq_pkg::IDX_W-1:0]      tail;
	logic                            full;
	logic signed [31:0]              ent_deadline;
	logic [tdwq_pkg::TASK_ID_BITS-1:0] ent_task;
	logic                            expired;
	logic [7:0]                      req_task;
	logic signed [31:0]              deadline;

	assign busy         = (state_q != IDLE);
	assign accept       = start && !busy;
	assign tail         = tdwq_pkg::wrap_add(head_q, count_q);
	assign full         = (count_q == tdwq_pkg::CNT_W'(tdwq_pkg::QUEUE_DEPTH));
	assign ent_deadline = rdata[tdwq_pkg::ENTRY_W-1 -: 32];
	assign ent_task     = rdata[tdwq_pkg::TASK_ID_BITS-1:0];
	assign expired      = (ent_deadline <= ticks_q);
	assign req_task     = tdwq_pkg::from_stored(tdwq_pkg::to_stored(cmd.task_id));
	assign deadline     = (cmd.kind == tdwq_pkg::KIND_DELAY) ?
	                      (cmd.tick_value + ticks_q) : cmd.tick_value;

	always_comb begin
		mreq = '0;
		emit = '0;
		case (state_q)
			IDLE: begin
				if (accept) begin
					case (cmd.kind)
						tdwq_pkg::KIND_TICK: begin
							emit.valid      = 1'b1;
							emit.reply_kind = tdwq_pkg::REPLY_ACK;
							emit.dest_task  = req_task;
						end
						tdwq_pkg::KIND_TIME: begin
							emit.valid      = 1'b1;
							emit.fin        = 1'b1;
							emit.reply_kind = tdwq_pkg::REPLY_TIME;
							emit.dest_task  = req_task;
							emit.time_value = ticks_q;
						end
						default: begin
							emit.fin = 1'b1;
							if (full) begin
								emit.valid      = 1'b1;
								emit.reply_kind = tdwq_pkg::REPLY_REJECT;
								emit.dest_task  = req_task;
							end else begin
								mreq.we    = 1'b1;
								mreq.waddr = tail;
								mreq.wdata = {deadline, tdwq_pkg::to_stored(cmd.task_id)};
							end
						end
					endcase
				end
			end
			SCAN: begin
				if (rem_q != '0) begin
					mreq.re    = 1'b1;
					mreq.raddr = rd_q;
				end
				if (vld_s1) begin
					if (expired) begin
						emit.valid      = 1'b1;
						emit.reply_kind = tdwq_pkg::REPLY_WAKE;
						emit.dest_task  = tdwq_pkg::from_stored(ent_task);
						emit.time_value = ticks_q;
					end else begin
						mreq.we    = 1'b1;
						mreq.waddr = wr_q;
						mreq.wdata = rdata;
					end
				end
			end
			FINISH: begin
				emit.fin = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= IDLE;
			ticks_q    <= '0;
			head_q     <= '0;
			count_q    <= '0;
			rd_q       <= '0;
			wr_q       <= '0;
			new_head_q <= '0;
			rem_q      <= '0;
			kept_q     <= '0;
			vld_s1     <= 1'b0;
		end else begin
			case (state_q)
				IDLE: begin
					if (accept) begin
						case (cmd.kind)
							tdwq_pkg::KIND_TICK: begin
								ticks_q    <= ticks_q + 32'sd1;
								rd_q       <= head_q;
								wr_q       <= tail;
								new_head_q <= tail;
								rem_q      <= count_q;
								kept_q     <= '0;
								vld_s1     <= 1'b0;
								state_q    <= (count_q == '0) ? FINISH : SCAN;
							end
							tdwq_pkg::KIND_TIME: begin
							end
							default: begin
								if (!full) begin
									count_q <= count_q + 1'b1;
								end
							end
						endcase
					end
				end
				SCAN: begin
					if (rem_q != '0) begin
						rd_q   <= tdwq_pkg::wrap_inc(rd_q);
						rem_q  <= rem_q - 1'b1;
						vld_s1 <= 1'b1;
					end else begin
						vld_s1 <= 1'b0;
					end
					if (vld_s1 && !expired) begin
						wr_q   <= tdwq_pkg::wrap_inc(wr_q);
						kept_q <= kept_q + 1'b1;
					end
					if (vld_s1 && rem_q == '0) begin
						head_q  <= new_head_q;
						count_q <= expired ? kept_q : kept_q + 1'b1;
						state_q <= FINISH;
					end
				end
				FINISH: begin
					state_q <= IDLE;
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

endmodule

@@ src/tdwq_out.sv @@
module tdwq_out (
	input  logic              clk,
	input  logic              arst_n,
	input  tdwq_pkg::emit_t   emit,
	output logic              strobe,
	output tdwq_pkg::result_t result
);

	logic              strobe_q;
	tdwq_pkg::result_t result_q;
	tdwq_pkg::result_t pend_q;
	logic              pend_vld_q;
	tdwq_pkg::result_t fresh;
	tdwq_pkg::result_t fresh_fin;
	tdwq_pkg::result_t pend_fin;

	// one result is held back until the next one or the end mark shows where last falls
	assign fresh = '{reply_kind: emit.reply_kind, dest_task: emit.dest_task,
	                 time_value: emit.time_value, last: 1'b0};
	assign fresh_fin = '{reply_kind: emit.reply_kind, dest_task: emit.dest_task,
	                     time_value: emit.time_value, last: 1'b1};
	assign pend_fin = '{reply_kind: pend_q.reply_kind, dest_task: pend_q.dest_task,
	                    time_value: pend_q.time_value, last: 1'b1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q   <= 1'b0;
			pend_vld_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			if (emit.valid && emit.fin) begin
				strobe_q <= 1'b1;
			end else if (emit.valid) begin
				strobe_q   <= pend_vld_q;
				pend_vld_q <= 1'b1;
			end else if (emit.fin) begin
				strobe_q   <= pend_vld_q;
				pend_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit.valid && emit.fin) begin
			result_q <= fresh_fin;
		end else if (emit.valid) begin
			result_q <= pend_q;
			pend_q   <= fresh;
		end else if (emit.fin) begin
			result_q <= pend_fin;
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

endmodule

@@ src/tick_delay_wakeup_queue.sv @@
// Time request and delay: busy stays low; a time reply or reject strobes next.
// Tick: raises busy and scans the queued sleepers, or goes straight to the finish state
// when the queue is empty; the scan reads one memory entry per cycle.
// A result waits until the next one or the scan end shows where last falls; the final
// result of a tick strobes in the first cycle with busy low. The receiver cannot stall.
// arst_n clears the counter, head and fill count; the queue memory is not cleared.
module tick_delay_wakeup_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  tdwq_pkg::cmd_t    cmd,
	output logic              busy,
	output logic              strobe,
	output tdwq_pkg::result_t result
);

	tdwq_pkg::mem_req_t                mreq;
	logic [tdwq_pkg::ENTRY_W-1:0]      rdata;
	tdwq_pkg::emit_t                   emit;

	tdwq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.mreq   (mreq),
		.rdata  (rdata),
		.emit   (emit)
	);

	tdwq_ram #(
		.DEPTH (tdwq_pkg::QUEUE_DEPTH),
		.WIDTH (tdwq_pkg::ENTRY_W),
		.AW    (tdwq_pkg::IDX_W)
	) u_ram (
		.clk   (clk),
		.we    (mreq.we),
		.waddr (mreq.waddr),
		.wdata (mreq.wdata),
		.re    (mreq.re),
		.raddr (mreq.raddr),
		.rdata (rdata)
	);

	tdwq_out u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.emit   (emit),
		.strobe (strobe),
		.result (result)
	);

endmodule

@@ src/tdwq_checker.sv @@
module tdwq_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input tdwq_pkg::cmd_t    cmd,
	input logic              busy,
	input logic              strobe,
	input tdwq_pkg::result_t result
);

	a_time_reply: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd.kind == tdwq_pkg::KIND_TIME |=>
		strobe && result.reply_kind == tdwq_pkg::REPLY_TIME && result.last)
		else $error("time request not answered next cycle");

	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd.kind == tdwq_pkg::KIND_TICK |=> busy)
		else $error("tick transfer did not raise busy");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (result.reply_kind == tdwq_pkg::REPLY_TIME ||
		           result.reply_kind == tdwq_pkg::REPLY_REJECT) |-> result.last)
		else $error("single-result reply without last");

	a_ack_zero: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.reply_kind == tdwq_pkg::REPLY_ACK |-> result.time_value == 32'sd0)
		else $error("tick acknowledge carries nonzero time");

endmodule

bind tick_delay_wakeup_queue tdwq_checker u_tdwq_checker (.*);

@@ sim/sleep_queue_checker.sv @@
module sleep_queue_checker
	import tdwq_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  logic    busy,
	input  cmd_t    cmd,
	input  logic    strobe,
	input  result_t result,
	output int      errors,
	output int      outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	logic signed [31:0]      sleep_deadline [QUEUE_DEPTH];
	logic [TASK_ID_BITS-1:0] sleep_task     [QUEUE_DEPTH];
	int unsigned             head_idx = 0;
	int unsigned             fill = 0;
	logic signed [31:0]      tick_count = '0;
	result_t                 expected_replies [$];
	int                      mismatch_count = 0;

	assign errors = mismatch_count;

	task automatic flag_mismatch(input string msg);
		$display("mismatch at %0t ns: %s", $time, msg);
		mismatch_count++;
	endtask

	function automatic void park_sleeper(input logic [TASK_ID_BITS-1:0] who,
			input logic signed [31:0] due);
		int unsigned slot;
		slot = (head_idx + fill) % QUEUE_DEPTH;
		sleep_deadline[slot] = due;
		sleep_task[slot]     = who;
		fill++;
	endfunction

	task automatic predict_replies(input cmd_t c);
		result_t                 batch [$];
		logic [TASK_ID_BITS-1:0] who;
		logic signed [31:0]      due;
		int unsigned             n;
		int unsigned             slot;
		who = TASK_ID_BITS'(c.task_id);
		case (c.kind)
		KIND_TICK: begin
			tick_count = tick_count + 32'sd1;
			batch.push_back('{REPLY_ACK, 8'(who), 32'sd0, 1'b0});
			n = fill;
			repeat (n) begin
				slot     = head_idx;
				head_idx = (head_idx + 1) % QUEUE_DEPTH;
				fill--;
				if (sleep_deadline[slot] <= tick_count) begin
					batch.push_back('{REPLY_WAKE, 8'(sleep_task[slot]), tick_count, 1'b0});
				end else begin
					park_sleeper(sleep_task[slot], sleep_deadline[slot]);
				end
			end
		end
		KIND_TIME: begin
			batch.push_back('{REPLY_TIME, 8'(who), tick_count, 1'b0});
		end
		default: begin
			due = (c.kind == KIND_DELAY) ? c.tick_value + tick_count : c.tick_value;
			if (fill >= QUEUE_DEPTH) begin
				batch.push_back('{REPLY_REJECT, 8'(who), 32'sd0, 1'b0});
			end else begin
				park_sleeper(who, due);
			end
		end
		endcase
		if (batch.size() > 0) begin
			batch[batch.size() - 1].last = 1'b1;
		end
		foreach (batch[i]) begin
			expected_replies.push_back(batch[i]);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		result_t want;
		if (!arst_n) begin
			head_idx   = 0;
			fill       = 0;
			tick_count = '0;
			expected_replies.delete();
		end else begin
			if (strobe) begin
				if (expected_replies.size() == 0) begin
					flag_mismatch($sformatf("result with nothing pending: %p", result));
				end else begin
					want = expected_replies.pop_front();
					if (result.reply_kind !== want.reply_kind)
						flag_mismatch($sformatf("reply_kind %s, want %s",
							result.reply_kind.name(), want.reply_kind.name()));
					if (result.dest_task !== want.dest_task)
						flag_mismatch($sformatf("dest_task %0d, want %0d",
							result.dest_task, want.dest_task));
					if (result.time_value !== want.time_value)
						flag_mismatch($sformatf("time_value %0d, want %0d",
							result.time_value, want.time_value));
					if (result.last !== want.last)
						flag_mismatch($sformatf("last %b, want %b", result.last, want.last));
				end
			end
			// transfer of a new command
			if (start && !busy) begin
				predict_replies(cmd);
			end
		end
		outstanding <= expected_replies.size();
	end

endmodule

@@ sim/tb_top.sv @@
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import tdwq_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int          RANDOM_ITEMS = 170;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	cmd_t               cmd = '0;
	logic               busy;
	logic               strobe;
	result_t            result;
	int                 errors;
	int                 outstanding;
	int unsigned        cycle_count = 0;
	int                 transfers = 0;
	bit                 idle_on = 1'b1;
	logic signed [31:0] sent_ticks = '0;

	tick_delay_wakeup_queue dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.strobe (strobe),
		.result (result)
	);

	sleep_queue_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.cmd         (cmd),
		.strobe      (strobe),
		.result      (result),
		.errors      (errors),
		.outstanding (outstanding)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("== FAIL ==");
		$finish;
	end

	task automatic send(input kind_t k, input logic [7:0] who, input logic signed [31:0] v);
		while (idle_on && $urandom_range(99) < 22) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		cmd   <= '{k, who, v};
		@(posedge clk);
		while (busy) @(posedge clk);
		if (k == KIND_TICK) sent_ticks = sent_ticks + 32'sd1;
		transfers++;
	endtask

	// mostly near-term deadlines so sleepers keep getting released
	task automatic send_sleeper();
		kind_t              k;
		int                 roll;
		logic signed [31:0] v;
		k    = $urandom_range(1) ? KIND_DELAY : KIND_UNTIL;
		roll = $urandom_range(99);
		if (roll < 6) v = $urandom;
		else if (roll < 14) v = -$signed(32'($urandom_range(40)));
		else v = $signed(32'($urandom_range(12)));
		if (k == KIND_UNTIL && roll >= 6) v = v + sent_ticks;
		send(k, 8'($urandom), v);
	endtask

	initial begin : stimulus
		int pick;
		int base;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		send(KIND_TIME, 8'h00, 32'sd0);
		send(KIND_TICK, 8'hFF, $urandom);
		send(KIND_DELAY, 8'hAA, 32'sh8000_0000);
		send(KIND_DELAY, 8'h55, 32'sh7FFF_FFFF);
		send(KIND_DELAY, 8'h01, 32'sd0);
		send(KIND_DELAY, 8'h02, -32'sd1);
		send(KIND_DELAY, 8'h03, 32'sd1);
		send(KIND_DELAY, 8'h04, 32'sd2);
		send(KIND_UNTIL, 8'h05, 32'sd0);
		send(KIND_UNTIL, 8'h06, 32'sh8000_0000);
		repeat (3) send(KIND_TICK, 8'($urandom), $urandom);
		send(KIND_TIME, 8'hFF, $urandom);

		// full queue of sleepers that all wake on the next tick
		repeat (QUEUE_DEPTH) send(KIND_UNTIL, 8'($urandom), 32'sh8000_0000 | $urandom);
		send(KIND_DELAY, 8'h7E, 32'sd5);
		send(KIND_UNTIL, 8'h81, 32'sd5);
		send(KIND_TICK, 8'h3C, 32'sd0);
		send(KIND_UNTIL, 8'hC3, 32'sh7FFF_FFFF);
		send(KIND_TICK, 8'h00, 32'sd0);
		send(KIND_TIME, 8'h11, 32'sd0);

		base = transfers;
		while (transfers - base < RANDOM_ITEMS) begin
			idle_on = !(transfers - base >= 60 && transfers - base < 120);
			pick    = $urandom_range(99);
			if (pick < 28) begin
				send(KIND_TICK, 8'($urandom), $urandom);
			end else if (pick < 38) begin
				send(KIND_TIME, 8'($urandom), $urandom);
			end else if (pick < 42) begin
				repeat ($urandom_range(8, 34)) send_sleeper();
			end else begin
				send_sleeper();
			end
		end

		start <= 1'b0;
		while (outstanding != 0) @(posedge clk);
		repeat (QUEUE_DEPTH + 8) @(posedge clk);
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
src/tdwq_pkg.sv
src/tdwq_ram.sv
src/tdwq_ctrl.sv
src/tdwq_out.sv
src/tick_delay_wakeup_queue.sv
src/tdwq_checker.sv
sim/sleep_queue_checker.sv
sim/tb_top.sv
